// ===== hdl/ikc_pkg.sv =====
// Shared types, constants and tap weights of the image kernel convolution block.
// No dependencies; ikc_cell, ikc_row_sum and the top module import it.
`default_nettype none

package ikc_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int KERNEL_SIZE_DEF = 9;

    localparam int PIX_W  = 24;
    localparam int MODE_W = 2;
    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 13;
    localparam int SUM_W  = 15;
    localparam int POS_W  = 25;

    localparam logic [FW_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] HEIGHT_RST = 13'd768;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOTION  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLUR    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd3;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    // Reciprocal of 13 in 16-bit fraction, rounded up.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_BLUR  = ((1 << RECIP_SHIFT) + 12) / 13;

    typedef logic signed [4:0] t_weight;

    function automatic t_weight tap_weight(input logic [MODE_W-1:0] mode,
                                           input int dx, input int dy);
        int      ax;
        int      ay;
        t_weight wt;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        case (mode)
            MODE_MOTION: begin
                wt = (dx == dy) ? 5'sd1 : 5'sd0;
            end
            MODE_BLUR: begin
                wt = (ax + ay <= 2) ? 5'sd1 : 5'sd0;
            end
            MODE_SHARPEN: begin
                if (ax > 2 || ay > 2) wt = 5'sd0;
                else if (ax == 0 && ay == 0) wt = 5'sd8;
                else if (ax <= 1 && ay <= 1) wt = 5'sd2;
                else wt = -5'sd1;
            end
            MODE_NONE: begin
                wt = (dx == 0 && dy == 0) ? 5'sd1 : 5'sd0;
            end
            default: begin
                wt = 5'sd0;
            end
        endcase
        return wt;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ikc_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none

module ikc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/ikc_cell.sv =====
// One window cell: a pixel register that shifts on each stepped beat.
// Depends on ikc_pkg.
`default_nettype none

module ikc_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic [ikc_pkg::PIX_W-1:0] i_d,
    output logic      [ikc_pkg::PIX_W-1:0] o_q
);
    import ikc_pkg::*;

    logic [PIX_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== hdl/ikc_row_sum.sv =====
// Weighted sum of one window row, per color channel, registered.
// Depends on ikc_pkg.
`default_nettype none

module ikc_row_sum #(
    parameter int KERNEL_SIZE = ikc_pkg::KERNEL_SIZE_DEF,
    parameter int ROW         = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [ikc_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [ikc_pkg::PIX_W-1:0]        i_pix [KERNEL_SIZE],
    input  wire logic [KERNEL_SIZE-1:0]           i_col_ok,
    input  wire logic                             i_row_ok,
    output logic signed [ikc_pkg::SUM_W-1:0]      o_sum [3]
);
    import ikc_pkg::*;

    localparam int HALF = KERNEL_SIZE / 2;

    logic signed [SUM_W-1:0] n_sum [3];
    logic signed [SUM_W-1:0] r_sum [3];

    always_comb begin
        t_weight                 wt;
        logic signed [SUM_W-1:0] chv;
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = '0;
        end
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            wt = tap_weight(i_mode, HALF - j, HALF - ROW);
            for (int c = 0; c < 3; c++) begin
                chv = SUM_W'($signed({1'b0, i_pix[j][PIX_W-1-8*c -: 8]}));
                if (i_row_ok && i_col_ok[j]) begin
                    n_sum[c] = n_sum[c] + SUM_W'(wt) * chv;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hdl/image_kernel_convolution_top.sv =====
// Image kernel convolution: window of cells fed by line RAMs, four-stage sum pipeline.
// One beat per cycle unless output back-pressure, the clearing pass or a configuration
// write holds beats off; a result leaves HALF*W+HALF beats after its pixel (HALF = K/2).
// A configuration write holds off beats for the next cycle while the frame bounds settle.
// Reset: synchronous, active low; then a clearing pass over all MAX_WIDTH slots zeroes
// the line RAMs, during which no beat is taken (configuration writes still are).
// Depends on ikc_pkg, ikc_ram, ikc_cell, ikc_row_sum.
`default_nettype none

module image_kernel_convolution_top #(
    parameter int MAX_WIDTH   = ikc_pkg::MAX_WIDTH_DEF,
    parameter int KERNEL_SIZE = ikc_pkg::KERNEL_SIZE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [ikc_pkg::PIX_W-1:0]  i_pixel_in,
    input  wire logic                       i_padding_beat,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [ikc_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                            o_frame_last,
    input  wire logic                       i_cfg_we,
    input  wire logic [ikc_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [ikc_pkg::CFG_W-1:0]  i_cfg_data
);
    import ikc_pkg::*;

    localparam int HALF    = KERNEL_SIZE / 2;
    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int CMPW    = FW_W + 3;
    localparam int RECIP_K = ((1 << RECIP_SHIFT) + KERNEL_SIZE - 1) / KERNEL_SIZE;
    localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);

    // Configuration registers.
    logic [MODE_W-1:0] r_mode;
    logic [FW_W-1:0]   r_width;
    logic [FH_W-1:0]   r_height;
    logic              r_cfg_stale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NONE;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_cfg_stale <= 1'b0;
        end else begin
            r_cfg_stale <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                    REG_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Effective frame size: zero acts as one, width limited to the line RAM depth.
    logic [CMPW-1:0]  w_ext;
    logic [FW_W-1:0]  weff;
    logic [FH_W-1:0]  heff;
    logic [POS_W-1:0] n_n;
    logic [POS_W-1:0] n_lag;
    logic [POS_W-1:0] r_n;
    logic [POS_W-1:0] r_lag;
    logic [POS_W-1:0] r_end;

    always_comb begin
        w_ext = CMPW'(r_width);
        if (r_width == '0) begin
            w_ext = CMPW'(1);
        end else if (w_ext > MAXW_C) begin
            w_ext = MAXW_C;
        end
        weff  = w_ext[FW_W-1:0];
        heff  = (r_height == '0) ? FH_W'(1) : r_height;
        n_n   = POS_W'(weff) * POS_W'(heff);
        n_lag = POS_W'(HALF) * POS_W'(weff) + POS_W'(HALF);
    end

    // Frame bounds follow the registers in the next cycle; hold off beats for that cycle.
    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_lag <= n_lag;
        r_end <= n_n + n_lag;
    end

    // Handshake and pipeline advance: the whole pipe moves when the output slot frees.
    logic r_v0, r_v1, r_v2, r_v3;
    logic r_clr;
    logic adv;
    logic acc;

    assign adv        = !r_v3 || i_out_ready;
    assign o_in_ready = adv && !r_clr && !r_cfg_stale;
    assign acc        = i_in_valid && o_in_ready;

    // Beat position within the frame: pixel phase, then flush phase.
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] pos_nxt;
    logic [POS_W-1:0] n_pos;
    logic             in_pix;
    logic             w_bubble;
    logic             step;
    logic             emit;

    always_comb begin
        pos_eff  = (r_pos >= r_end) ? '0 : r_pos;
        in_pix   = pos_eff < r_n;
        w_bubble = in_pix && i_padding_beat;
        step     = acc && !w_bubble;
        emit     = pos_eff >= r_lag;
        pos_nxt  = pos_eff + POS_W'(1);
        n_pos    = (pos_nxt >= r_end) ? '0 : pos_nxt;
    end

    // Column and row of the output pixel; restart at the first emitting beat.
    logic [FW_W-1:0] r_ox, cur_ox, n_ox;
    logic [FH_W-1:0] r_oy, cur_oy, n_oy;
    logic [KERNEL_SIZE-1:0] n_colok, r_colok;
    logic [KERNEL_SIZE-1:0] n_rowok, r_rowok;
    logic                   n_last;

    always_comb begin
        int xs;
        int ys;
        cur_ox = (pos_eff == r_lag) ? '0 : r_ox;
        cur_oy = (pos_eff == r_lag) ? '0 : r_oy;
        if (cur_ox == weff - FW_W'(1)) begin
            n_ox = '0;
            n_oy = cur_oy + FH_W'(1);
        end else begin
            n_ox = cur_ox + FW_W'(1);
            n_oy = cur_oy;
        end
        // Drop taps that fall outside the frame.
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            xs         = int'(cur_ox) + HALF - j;
            n_colok[j] = (xs >= 0) && (xs < int'(weff));
        end
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            ys         = int'(cur_oy) + HALF - k;
            n_rowok[k] = (ys >= 0) && (ys < int'(heff));
        end
        n_last = (cur_ox == weff - FW_W'(1)) && (cur_oy == heff - FH_W'(1));
    end

    // Line RAM pointer cycles over the active width; clearing pass after reset.
    // A pointer left beyond a narrower width restarts at slot zero.
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] ptr_eff;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] r_clr_addr;

    always_comb begin
        ptr_eff = (CMPW'(r_ptr) >= CMPW'(weff)) ? '0 : r_ptr;
        if (CMPW'(ptr_eff) >= CMPW'(weff) - CMPW'(1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = ptr_eff + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_ptr      <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (step) begin
                r_pos <= n_pos;
                r_ptr <= n_ptr;
                if (emit) begin
                    r_ox <= n_ox;
                    r_oy <= n_oy;
                end
            end
        end
    end

    // Window: row k holds the stream delayed by k lines, cell j by j more beats.
    logic [PIX_W-1:0] wr_val;
    logic [PIX_W-1:0] w_win   [KERNEL_SIZE][KERNEL_SIZE];
    logic [PIX_W-1:0] w_feed  [KERNEL_SIZE];
    logic [PIX_W-1:0] w_rdata [KERNEL_SIZE];

    // Flush beats shift in black.
    assign wr_val    = in_pix ? i_pixel_in : '0;
    assign w_feed[0] = wr_val;
    assign w_rdata[0] = '0;

    genvar gk, gj;
    generate
        for (gk = 1; gk < KERNEL_SIZE; gk++) begin : g_line
            logic [PIX_W-1:0] ram_wdata;
            logic [AW-1:0]    ram_waddr;
            logic [AW-1:0]    ram_raddr;

            assign ram_wdata = r_clr ? '0 : w_feed[gk-1];
            assign ram_waddr = r_clr ? r_clr_addr : ptr_eff;
            assign ram_raddr = step ? n_ptr : ptr_eff;

            ikc_ram #(
                .WIDTH (PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_line (
                .i_clk   (i_clk),
                .i_we    (r_clr || step),
                .i_waddr (ram_waddr),
                .i_wdata (ram_wdata),
                .i_raddr (ram_raddr),
                .o_rdata (w_rdata[gk])
            );

            // A one-pixel line is just the cell above.
            assign w_feed[gk] = (weff == FW_W'(1)) ? w_win[gk-1][0] : w_rdata[gk];
        end

        for (gk = 0; gk < KERNEL_SIZE; gk++) begin : g_row
            for (gj = 0; gj < KERNEL_SIZE; gj++) begin : g_col
                ikc_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (step),
                    .i_d     ((gj == 0) ? w_feed[gk] : w_win[gk][(gj == 0) ? 0 : gj-1]),
                    .o_q     (w_win[gk][gj])
                );
            end
        end
    endgenerate

    // Valid flags of all stages; stage 0 control sits beside the window.
    logic r_last0, r_last1, r_last2, r_last3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v0 <= step && emit;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: one registered sum per window row.
    logic signed [SUM_W-1:0] w_rsum [KERNEL_SIZE][3];

    generate
        for (gk = 0; gk < KERNEL_SIZE; gk++) begin : g_sum
            ikc_row_sum #(
                .KERNEL_SIZE (KERNEL_SIZE),
                .ROW         (gk)
            ) u_row_sum (
                .i_clk    (i_clk),
                .i_en     (adv),
                .i_mode   (r_mode),
                .i_pix    (w_win[gk]),
                .i_col_ok (r_colok),
                .i_row_ok (r_rowok[gk]),
                .o_sum    (w_rsum[gk])
            );
        end
    endgenerate

    // Stage 2: total per channel.
    logic signed [SUM_W-1:0] n_tot [3];
    logic signed [SUM_W-1:0] r_tot [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_tot[c] = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) begin
                n_tot[c] = n_tot[c] + w_rsum[k][c];
            end
        end
    end

    // Stage 3: divide by the mode's factor, truncate, clamp to a byte.
    logic [PIX_W-1:0] n_out;
    logic [PIX_W-1:0] r_out;

    always_comb begin
        logic [SUM_W-1:0] sp;
        logic [31:0]      prod;
        logic [15:0]      q;
        for (int c = 0; c < 3; c++) begin
            sp   = r_tot[c];
            prod = '0;
            case (r_mode)
                MODE_MOTION: begin
                    prod = 32'(sp) * 32'(RECIP_K);
                    q    = prod[31:16];
                end
                MODE_BLUR: begin
                    prod = 32'(sp) * 32'(RECIP_BLUR);
                    q    = prod[31:16];
                end
                MODE_SHARPEN: begin
                    q = 16'(sp >> 3);
                end
                default: begin
                    q = 16'(sp);
                end
            endcase
            if (r_tot[c] <= 0) begin
                n_out[PIX_W-1-8*c -: 8] = 8'd0;
            end else if (q > 16'd255) begin
                n_out[PIX_W-1-8*c -: 8] = 8'hFF;
            end else begin
                n_out[PIX_W-1-8*c -: 8] = q[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_colok <= n_colok;
            r_rowok <= n_rowok;
            r_last0 <= n_last;
            r_last1 <= r_last0;
            r_last2 <= r_last1;
            r_last3 <= r_last2;
            r_tot   <= n_tot;
            r_out   <= n_out;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_pixel_out  = r_out;
    assign o_frame_last = r_last3;

    // No beat is taken while the line RAMs are being cleared.
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_in_ready)
        else $error("beat taken during clearing pass");

    // A padding beat in the pixel phase produces nothing.
    a_bubble_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && w_bubble) |=> !r_v0)
        else $error("bubble beat produced a result");

    // The pointer starts at slot zero when the clearing pass ends.
    a_ptr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr && $past(r_clr)) |-> (r_ptr == '0))
        else $error("line pointer moved during clearing");

endmodule

`default_nettype wire
